FILE: hdl/kdlp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kdlp_pkg
// Shared types and constants for the key debounce / long-short press block.
// ----------------------------------------------------------------------------
package kdlp_pkg;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_DEB    = 2'd1,
        ST_STABLE = 2'd2
    } fsm_state_t;

    typedef enum logic [1:0] {
        EV_PRESSED  = 2'd0,
        EV_RELEASED = 2'd1,
        EV_SHORT    = 2'd2,
        EV_LONG     = 2'd3
    } ev_code_t;

    // configuration register indexes
    localparam logic [1:0] REG_ACTIVE_HIGH = 2'd0;
    localparam logic [1:0] REG_DEBOUNCE    = 2'd1;
    localparam logic [1:0] REG_LONG_PRESS  = 2'd2;

    localparam logic [15:0] DEBOUNCE_RST   = 16'd20;
    localparam logic [15:0] LONG_PRESS_RST = 16'd1000;

    // result queue geometry
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    typedef struct packed {
        logic        pin_level;
        logic [31:0] tick_now;
    } scan_t;

    typedef struct packed {
        ev_code_t event_code;
        logic     last_event;
    } event_t;

    typedef struct packed {
        logic        active_high;
        logic [15:0] debounce_time;
        logic [15:0] long_press_time;
    } cfg_t;

    // events produced by one scan
    typedef struct packed {
        logic [1:0] count;
        event_t     first;
        event_t     second;
    } step_t;

endpackage : kdlp_pkg
`default_nettype wire

FILE: hdl/kdlp_fsm.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kdlp_fsm
// Debounce state machine and press timers; one scan evaluated per fire.
// ----------------------------------------------------------------------------
module kdlp_fsm (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire kdlp_pkg::cfg_t  cfg,
    input  wire kdlp_pkg::scan_t scan,
    input  wire logic          fire,
    output kdlp_pkg::step_t    step
);

    kdlp_pkg::fsm_state_t state_reg, state_next;
    logic        stable_reg, stable_next;
    logic [31:0] change_tick_reg, change_tick_next;
    logic [31:0] press_start_reg, press_start_next;
    logic        long_fired_reg, long_fired_next;

    logic        pressed;
    logic [31:0] since_change;
    logic [31:0] since_press;
    logic        deb_done;
    logic        long_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= kdlp_pkg::ST_IDLE;
            stable_reg      <= 1'b0;
            change_tick_reg <= '0;
            press_start_reg <= '0;
            long_fired_reg  <= 1'b0;
        end
        else if (fire)
        begin
            state_reg       <= state_next;
            stable_reg      <= stable_next;
            change_tick_reg <= change_tick_next;
            press_start_reg <= press_start_next;
            long_fired_reg  <= long_fired_next;
        end
    end

    assign pressed      = cfg.active_high ? scan.pin_level : ~scan.pin_level;
    assign since_change = scan.tick_now - change_tick_reg;
    assign since_press  = scan.tick_now - press_start_reg;
    assign deb_done     = since_change >= {16'd0, cfg.debounce_time};
    assign long_done    = since_press >= {16'd0, cfg.long_press_time};

    always_comb
    begin
        state_next       = state_reg;
        stable_next      = stable_reg;
        change_tick_next = change_tick_reg;
        press_start_next = press_start_reg;
        long_fired_next  = long_fired_reg;
        step.count             = 2'd0;
        step.first.event_code  = kdlp_pkg::EV_PRESSED;
        step.first.last_event  = 1'b0;
        step.second.event_code = kdlp_pkg::EV_SHORT;
        step.second.last_event = 1'b1;

        case (state_reg)
            kdlp_pkg::ST_IDLE:
            begin
                if (pressed != stable_reg)
                begin
                    state_next       = kdlp_pkg::ST_DEB;
                    change_tick_next = scan.tick_now;
                end
            end
            kdlp_pkg::ST_DEB:
            begin
                if (pressed != stable_reg)
                begin
                    if (deb_done)
                    begin
                        stable_next = pressed;
                        state_next  = kdlp_pkg::ST_STABLE;
                        if (pressed)
                        begin
                            press_start_next      = scan.tick_now;
                            long_fired_next       = 1'b0;
                            step.count            = 2'd1;
                            step.first.event_code = kdlp_pkg::EV_PRESSED;
                        end
                        else
                        begin
                            step.first.event_code = kdlp_pkg::EV_RELEASED;
                            step.count            = long_fired_reg ? 2'd1 : 2'd2;
                        end
                    end
                end
                else
                begin
                    state_next = stable_reg ? kdlp_pkg::ST_STABLE : kdlp_pkg::ST_IDLE;
                end
            end
            kdlp_pkg::ST_STABLE:
            begin
                if (pressed != stable_reg)
                begin
                    state_next       = kdlp_pkg::ST_DEB;
                    change_tick_next = scan.tick_now;
                end
                else if (pressed && !long_fired_reg && long_done)
                begin
                    long_fired_next       = 1'b1;
                    step.count            = 2'd1;
                    step.first.event_code = kdlp_pkg::EV_LONG;
                end
            end
            default:
            begin
                state_next = kdlp_pkg::ST_IDLE;
            end
        endcase

        step.first.last_event = (step.count == 2'd1);
    end

endmodule : kdlp_fsm
`default_nettype wire

FILE: hdl/kdlp_evq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kdlp_evq
// Small result queue: up to two pushes and one pop per cycle.
// ----------------------------------------------------------------------------
module kdlp_evq (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [1:0]                    push_count,
    input  wire kdlp_pkg::event_t              push0,
    input  wire kdlp_pkg::event_t              push1,
    input  wire logic                          pop,
    output kdlp_pkg::event_t                   head,
    output logic                               not_empty,
    output logic [kdlp_pkg::FIFO_CW-1:0]       level
);

    kdlp_pkg::event_t mem [kdlp_pkg::FIFO_DEPTH];

    logic [kdlp_pkg::FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [kdlp_pkg::FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [kdlp_pkg::FIFO_AW-1:0] wr_ptr_inc;
    logic [kdlp_pkg::FIFO_CW-1:0] level_reg, level_next;

    assign wr_ptr_inc  = wr_ptr_reg + kdlp_pkg::FIFO_AW'(1);
    assign wr_ptr_next = wr_ptr_reg + kdlp_pkg::FIFO_AW'(push_count);
    assign rd_ptr_next = rd_ptr_reg + kdlp_pkg::FIFO_AW'(pop);
    assign level_next  = level_reg + kdlp_pkg::FIFO_CW'(push_count)
                       - kdlp_pkg::FIFO_CW'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push0;
        end
        if (push_count == 2'd2)
        begin
            mem[wr_ptr_inc] <= push1;
        end
    end

    assign head      = mem[rd_ptr_reg];
    assign not_empty = (level_reg != '0);
    assign level     = level_reg;

endmodule : kdlp_evq
`default_nettype wire

FILE: hdl/key_debounce_long_short_press_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// key_debounce_long_short_press_top
// Key debouncer with pressed / released / short-press / long-press events.
// ----------------------------------------------------------------------------
//  channel | dir | handshake                | payload
//  scan    | in  | scan_valid / scan_ready  | kdlp_pkg::scan_t  (pin_level, tick_now)
//  evt     | out | evt_valid  / evt_ready   | kdlp_pkg::event_t (event_code, last_event)
//  cfg     | in  | cfg_we                   | cfg_index [1:0], cfg_data [15:0]
//
//  One scan beat is taken per cycle while the input register is free or its
//  held scan is evaluated; the scan is held in the input register, evaluated
//  by the state machine and its events (zero to two) pushed into a four-entry
//  queue memory; a release plus short-press pair drains over two output beats.
//  A scan is evaluated only when the queue has room for two events, so a
//  stalled output backs up into scan_ready after the queue fills.
//  Reset clears the state machine and queue and loads the default settings.
// ----------------------------------------------------------------------------
module key_debounce_long_short_press_top (
    input  wire logic             clk,
    input  wire logic             rst_n,
    // scan input
    input  wire logic             scan_valid,
    output logic                  scan_ready,
    input  wire kdlp_pkg::scan_t  scan,
    // event output
    output logic                  evt_valid,
    input  wire logic             evt_ready,
    output kdlp_pkg::event_t      evt,
    // configuration writes
    input  wire logic             cfg_we,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [15:0]      cfg_data
);

    // highest queue level at which a scan is still evaluated (room for two events)
    localparam logic [kdlp_pkg::FIFO_CW-1:0] LEVEL_LIMIT =
        kdlp_pkg::FIFO_CW'(kdlp_pkg::FIFO_DEPTH - 2);

    kdlp_pkg::cfg_t   cfg_reg;
    kdlp_pkg::scan_t  held_reg;
    logic             held_valid_reg, held_valid_next;
    logic             scan_fire;
    logic             proc_fire;
    logic             pop;
    kdlp_pkg::step_t  step;
    logic [kdlp_pkg::FIFO_CW-1:0] level;

    // settings: unknown index is simply dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.active_high     <= 1'b0;
            cfg_reg.debounce_time   <= kdlp_pkg::DEBOUNCE_RST;
            cfg_reg.long_press_time <= kdlp_pkg::LONG_PRESS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                kdlp_pkg::REG_ACTIVE_HIGH: cfg_reg.active_high     <= cfg_data[0];
                kdlp_pkg::REG_DEBOUNCE:    cfg_reg.debounce_time   <= cfg_data;
                kdlp_pkg::REG_LONG_PRESS:  cfg_reg.long_press_time <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // input register: refills in the same cycle the held scan is evaluated
    assign proc_fire       = held_valid_reg && (level <= LEVEL_LIMIT);
    assign scan_ready      = !held_valid_reg || proc_fire;
    assign scan_fire       = scan_valid && scan_ready;
    assign held_valid_next = scan_fire || (held_valid_reg && !proc_fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_fire)
        begin
            held_reg <= scan;
        end
    end

    kdlp_fsm u_fsm (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .scan  (held_reg),
        .fire  (proc_fire),
        .step  (step)
    );

    assign pop = evt_valid && evt_ready;

    kdlp_evq u_evq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (proc_fire ? step.count : 2'd0),
        .push0      (step.first),
        .push1      (step.second),
        .pop        (pop),
        .head       (evt),
        .not_empty  (evt_valid),
        .level      (level)
    );

`ifndef SYNTHESIS
    // a pair of events is only ever release followed by short press
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (proc_fire && step.count == 2'd2) |->
        (step.first.event_code == kdlp_pkg::EV_RELEASED &&
         step.second.event_code == kdlp_pkg::EV_SHORT))
        else $error("event pair out of order");

    // a held scan that is not evaluated stays put
    a_held_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (held_valid_reg && !proc_fire) |=> (held_valid_reg && $stable(held_reg)))
        else $error("held scan lost or changed");

    // queue never overfills
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level <= kdlp_pkg::FIFO_CW'(kdlp_pkg::FIFO_DEPTH))
        else $error("event queue overflow");
`endif

endmodule : key_debounce_long_short_press_top
`default_nettype wire

FILE: dv/tb_key_debounce_long_short_press_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_key_debounce_long_short_press_top
// Self-checking bench for the key debouncer. Scan beats go in on a
// valid/ready channel. A local copy of the press state machine works out the
// events that each accepted scan should raise. Every event beat is checked in
// order against them. Directed scans cover the timing edges. Random key
// strokes with chatter and noise then run under several register settings.
// ----------------------------------------------------------------------------
module tb_key_debounce_long_short_press_top;

    // index that decodes to no register
    localparam logic [1:0]  REG_UNUSED      = 2'd3;
    // cycles allowed after the last event for scans that raise nothing
    localparam int unsigned SETTLE_CYCLES   = 8;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned PHASE_SCANS     = 180;
    localparam int unsigned NUM_PHASES      = 8;

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              scan_valid = 1'b0;
    logic              scan_ready;
    kdlp_pkg::scan_t   scan       = '0;
    logic              evt_valid;
    logic              evt_ready  = 1'b0;
    kdlp_pkg::event_t  evt;
    logic              cfg_we     = 1'b0;
    logic [1:0]        cfg_index  = '0;
    logic [15:0]       cfg_data   = '0;

    // predictor state: a copy of the settings and of the press machine
    kdlp_pkg::cfg_t        key_cfg;
    kdlp_pkg::fsm_state_t  key_state;
    logic                  key_down;
    logic [31:0]           chg_tick;
    logic [31:0]           down_tick;
    logic                  long_seen;
    kdlp_pkg::event_t      pending_events[$];

    int unsigned errors       = 0;
    int unsigned scans_sent   = 0;
    logic [31:0] cur_tick     = '0;
    // quiet: no idling on either side; hold_off_req: one long sink stall
    bit          quiet        = 1'b0;
    bit          hold_off_req = 1'b0;

    key_debounce_long_short_press_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .scan_valid (scan_valid),
        .scan_ready (scan_ready),
        .scan       (scan),
        .evt_valid  (evt_valid),
        .evt_ready  (evt_ready),
        .evt        (evt),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Event prediction for one accepted scan. Tick differences wrap at 32 bits
    // through the unsigned subtraction into a 32-bit variable.
    // ------------------------------------------------------------------------
    task automatic predict_key_events(input kdlp_pkg::scan_t s);
        logic                pressed;
        logic [31:0]         elapsed;
        kdlp_pkg::ev_code_t  codes[$];
        kdlp_pkg::event_t    e;
        pressed = key_cfg.active_high ? s.pin_level : ~s.pin_level;
        case (key_state)
            kdlp_pkg::ST_IDLE:
            begin
                if (pressed != key_down)
                begin
                    key_state = kdlp_pkg::ST_DEB;
                    chg_tick  = s.tick_now;
                end
            end
            kdlp_pkg::ST_DEB:
            begin
                if (pressed == key_down)
                begin
                    // bounced back to the accepted level
                    if (key_down)
                        key_state = kdlp_pkg::ST_STABLE;
                    else
                        key_state = kdlp_pkg::ST_IDLE;
                end
                else
                begin
                    elapsed = s.tick_now - chg_tick;
                    if (elapsed >= 32'(key_cfg.debounce_time))
                    begin
                        key_down  = pressed;
                        key_state = kdlp_pkg::ST_STABLE;
                        if (pressed)
                        begin
                            down_tick = s.tick_now;
                            long_seen = 1'b0;
                            codes.push_back(kdlp_pkg::EV_PRESSED);
                        end
                        else
                        begin
                            codes.push_back(kdlp_pkg::EV_RELEASED);
                            if (!long_seen)
                                codes.push_back(kdlp_pkg::EV_SHORT);
                        end
                    end
                end
            end
            kdlp_pkg::ST_STABLE:
            begin
                if (pressed != key_down)
                begin
                    key_state = kdlp_pkg::ST_DEB;
                    chg_tick  = s.tick_now;
                end
                else if (pressed && !long_seen)
                begin
                    elapsed = s.tick_now - down_tick;
                    if (elapsed >= 32'(key_cfg.long_press_time))
                    begin
                        long_seen = 1'b1;
                        codes.push_back(kdlp_pkg::EV_LONG);
                    end
                end
            end
            // spare state code: back to idle, silent (not reachable from pins)
            default: key_state = kdlp_pkg::ST_IDLE;
        endcase
        foreach (codes[i])
        begin
            e.event_code = codes[i];
            e.last_event = (i == codes.size() - 1);
            pending_events.push_back(e);
        end
    endtask

    // ------------------------------------------------------------------------
    // Scoreboard. Both channels are sampled at the rising edge, before the
    // nonblocking updates of that edge land. Prediction goes first so that
    // nothing hangs on process order.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : evt_check
        kdlp_pkg::event_t want;
        if (rst_n)
        begin
            if (scan_valid && scan_ready)
                predict_key_events(scan);
            if (evt_valid && evt_ready)
            begin
                if (pending_events.size() == 0)
                begin
                    $display("%0t: event beat with none expected, got code %0d last %0b",
                             $time, evt.event_code, evt.last_event);
                    errors++;
                end
                else
                begin
                    want = pending_events.pop_front();
                    if (evt.event_code !== want.event_code)
                    begin
                        $display("%0t: event_code expected %0d, got %0d",
                                 $time, want.event_code, evt.event_code);
                        errors++;
                    end
                    if (evt.last_event !== want.last_event)
                    begin
                        $display("%0t: last_event expected %0b, got %0b",
                                 $time, want.last_event, evt.last_event);
                        errors++;
                    end
                end
            end
        end
    end

    // mostly short stalls, now and then a long one; never zero
    function automatic int unsigned idle_len();
        if ($urandom_range(0, 9) != 0)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int unsigned send_gap();
        if (quiet || $urandom_range(0, 1) == 0)
            return 0;
        return idle_len();
    endfunction

    // ------------------------------------------------------------------------
    // Event sink: random ready gaps, or one long hold-off on request, counted
    // here in cycles. Ready is lowered and raised on different edges.
    // ------------------------------------------------------------------------
    initial
    begin : evt_sink
        int unsigned n;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                evt_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                evt_ready <= 1'b0;
                n = idle_len();
                repeat (n) @(posedge clk);
            end
            evt_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // One scan beat. Valid stays high from one beat to the next unless a gap
    // is drawn, so it is never dropped and raised in the same step.
    // ------------------------------------------------------------------------
    task automatic send_scan(input logic pin, input logic [31:0] tick);
        int unsigned gap;
        gap = send_gap();
        if (gap != 0)
        begin
            scan_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        scan_valid <= 1'b1;
        scan       <= '{pin_level: pin, tick_now: tick};
        @(posedge clk);
        while (!scan_ready)
            @(posedge clk);
        scans_sent++;
    endtask

    // scan by logical key level, tick moved on by dt
    task automatic scan_key(input logic pressed, input logic [31:0] dt);
        cur_tick = cur_tick + dt;
        send_scan(key_cfg.active_high ? pressed : ~pressed, cur_tick);
    endtask

    // stop offering, wait for every expected event, then let the pipe settle
    task automatic wait_drained();
        scan_valid <= 1'b0;
        @(posedge clk);
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register write; only called while the block is idle
    task automatic write_setting(input logic [1:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        case (idx)
            kdlp_pkg::REG_ACTIVE_HIGH: key_cfg.active_high     = val[0];
            kdlp_pkg::REG_DEBOUNCE:    key_cfg.debounce_time   = val;
            kdlp_pkg::REG_LONG_PRESS:  key_cfg.long_press_time = val;
            default: ;  // no register behind this index
        endcase
    endtask

    task automatic apply_settings(input logic ah, input logic [15:0] dbt,
                                  input logic [15:0] lpt);
        write_setting(kdlp_pkg::REG_ACTIVE_HIGH, {15'd0, ah});
        write_setting(kdlp_pkg::REG_DEBOUNCE, dbt);
        write_setting(kdlp_pkg::REG_LONG_PRESS, lpt);
    endtask

    // ------------------------------------------------------------------------
    // A well-formed key stroke: chatter, press confirm, hold (short or past
    // the long-press time), chatter, release confirm, a little idle.
    // ------------------------------------------------------------------------
    task automatic chatter(input logic lvl);
        repeat ($urandom_range(0, 2))
        begin
            scan_key(lvl, $urandom_range(1, 3));
            scan_key(~lvl, $urandom_range(1, 3));
        end
    endtask

    task automatic key_stroke();
        int unsigned dbt;
        int unsigned lpt;
        int unsigned hold;
        int unsigned k;
        dbt = key_cfg.debounce_time;
        lpt = key_cfg.long_press_time;
        chatter(1'b1);
        scan_key(1'b1, $urandom_range(1, 5));
        scan_key(1'b1, dbt + $urandom_range(0, 2));
        k = $urandom_range(1, 6);
        if ($urandom_range(0, 1) == 0)
            hold = $urandom_range(0, lpt);
        else
            hold = lpt + $urandom_range(0, lpt / 2 + 3);
        repeat (k) scan_key(1'b1, hold / k);
        chatter(1'b0);
        scan_key(1'b0, $urandom_range(1, 5));
        scan_key(1'b0, dbt + $urandom_range(0, 2));
        repeat ($urandom_range(0, 2)) scan_key(1'b0, $urandom_range(1, 50));
    endtask

    // random pin levels, tick jumps short or across the whole range
    task automatic noise_burst();
        logic [31:0] dt;
        repeat ($urandom_range(1, 6))
        begin
            if ($urandom_range(0, 3) == 0)
                dt = $urandom;
            else
                dt = $urandom_range(0, 60);
            cur_tick = cur_tick + dt;
            send_scan(1'($urandom_range(0, 1)), cur_tick);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // reset settings (active low, 20, 1000): debounce and long-press edges
    // one tick either side, long press suppressing short, bounces back to
    // idle and back to stable
    task automatic test_reset_defaults();
        scan_key(1'b0, 0);
        scan_key(1'b1, 5);
        scan_key(1'b1, 19);     // one tick short of debounce
        scan_key(1'b1, 1);      // pressed
        scan_key(1'b1, 999);    // one tick short of long press
        scan_key(1'b1, 1);      // long press
        scan_key(1'b1, 5);      // fires only once
        scan_key(1'b0, 0);
        scan_key(1'b0, 20);     // released, no short press
        scan_key(1'b1, 10);
        scan_key(1'b0, 1);      // bounce while released: back to idle
        scan_key(1'b1, 9);
        scan_key(1'b1, 20);     // pressed
        scan_key(1'b0, 10);
        scan_key(1'b1, 1);      // bounce while held: back to stable
        scan_key(1'b0, 9);
        scan_key(1'b0, 20);     // released + short press
        wait_drained();
    endtask

    // zero debounce: confirm on the next scan; zero long press: first held scan
    task automatic test_zero_times();
        apply_settings(1'b1, 16'd0, 16'd0);
        scan_key(1'b1, 3);
        scan_key(1'b1, 0);      // pressed
        scan_key(1'b1, 0);      // long press
        scan_key(1'b0, 1);
        scan_key(1'b0, 0);      // released only
        scan_key(1'b1, 0);
        scan_key(1'b1, 0);      // pressed
        scan_key(1'b0, 1);      // release starts before any held scan
        scan_key(1'b0, 0);      // released + short press
        wait_drained();
    endtask

    // full-scale times across the tick wrap; a write to the spare index and
    // an over-wide polarity value (only bit 0 kept)
    task automatic test_wide_settings();
        write_setting(REG_UNUSED, 16'hFFFF);
        write_setting(kdlp_pkg::REG_ACTIVE_HIGH, 16'hFFFE);
        write_setting(kdlp_pkg::REG_DEBOUNCE, 16'hFFFF);
        write_setting(kdlp_pkg::REG_LONG_PRESS, 16'hFFFF);
        cur_tick = 32'hFFFF_FFF0;
        scan_key(1'b0, 0);
        scan_key(1'b1, 0);
        scan_key(1'b1, 65534);
        scan_key(1'b1, 1);      // pressed, tick has wrapped
        scan_key(1'b1, 65534);
        scan_key(1'b1, 1);      // long press
        scan_key(1'b0, 0);
        scan_key(1'b0, 65535);  // released
        cur_tick = 32'hFFFF_FFFF;
        scan_key(1'b0, 0);
        scan_key(1'b0, 1);      // tick 0
        wait_drained();
    endtask

    // sink holds off while short strokes keep coming: queue fills, input stalls
    task automatic test_backpressure();
        apply_settings(1'b1, 16'd0, 16'hFFFF);
        hold_off_req = 1'b1;
        repeat (10)
        begin
            scan_key(1'b1, 1);
            scan_key(1'b1, 0);  // pressed
            scan_key(1'b0, 1);
            scan_key(1'b0, 0);  // released + short press
        end
        wait_drained();
    endtask

    // random strokes and noise under a run of settings, extremes among them;
    // one phase runs with no idling at all
    task automatic test_random_phases();
        logic [15:0] dbt;
        logic [15:0] lpt;
        int unsigned target;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                1:       dbt = 16'd0;
                2:       dbt = 16'hFFFF;
                default: dbt = 16'($urandom_range(0, 40));
            endcase
            case (p)
                3:       lpt = 16'd0;
                4:       lpt = 16'hFFFF;
                6:       lpt = 16'($urandom_range(0, 65535));
                default: lpt = 16'($urandom_range(0, 300));
            endcase
            quiet = (p == 5);
            apply_settings(p[0], dbt, lpt);
            target = scans_sent + PHASE_SCANS;
            while (scans_sent < target)
            begin
                if ($urandom_range(0, 4) != 0)
                    key_stroke();
                else
                    noise_burst();
            end
            wait_drained();
        end
        quiet = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Run
    // ------------------------------------------------------------------------
    initial
    begin : run
        key_cfg   = '{active_high: 1'b0, debounce_time: kdlp_pkg::DEBOUNCE_RST,
                      long_press_time: kdlp_pkg::LONG_PRESS_RST};
        key_state = kdlp_pkg::ST_IDLE;
        key_down  = 1'b0;
        chg_tick  = '0;
        down_tick = '0;
        long_seen = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_zero_times();
        test_wide_settings();
        test_backpressure();
        test_random_phases();
        if (errors == 0 && pending_events.size() == 0)
            $display("** key_debounce_long_short_press_top: PASSED **");
        else
            $display("** key_debounce_long_short_press_top: FAILED **");
        $finish;
    end

    // watchdog: several times the slowest legal run
    initial
    begin : watchdog
        #10_000_000;
        $display("** key_debounce_long_short_press_top: FAILED **");
        $finish;
    end

endmodule
